// File: rtl/core/pfde_pkg.sv
// Shared command codes, constants and types of the page framebuffer draw engine.
package pfde_pkg;

    // Command codes of the input request
    localparam logic [2:0] CMD_SET_PIXEL = 3'd0;
    localparam logic [2:0] CMD_CLR_PIXEL = 3'd1;
    localparam logic [2:0] CMD_SET_HSPAN = 3'd2;
    localparam logic [2:0] CMD_CLR_HSPAN = 3'd3;
    localparam logic [2:0] CMD_SET_VSPAN = 3'd4;
    localparam logic [2:0] CMD_RECT      = 3'd5;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd6;
    localparam logic [2:0] CMD_READ      = 3'd7;

    // Pixel rows per store byte
    localparam int PAGE_ROWS = 8;

    // Coordinates after rectangle sums (x + w reaches 2046)
    localparam int COORD_W = 11;

    // Register reset values
    localparam logic [6:0] LEFT_OFFSET_RST = 7'd0;
    localparam logic [7:0] RIGHT_LIMIT_RST = 8'd128;

    // Result of the pixel address unit
    typedef struct packed {
        logic       hit;
        logic [7:0] mask;
    } t_pix_stat;

endpackage

// File: rtl/core/pfde_frame_mem.sv
// Byte-wide frame store with one write port and one registered read port.
module pfde_frame_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_re,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/pfde_pixel_unit.sv
// Shared pixel unit: clips one shifted pixel and forms its byte address and bit mask.
module pfde_pixel_unit
    import pfde_pkg::*;
#(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64,
    parameter int AW     = 10
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    input  logic [6:0]         i_left_offset,
    input  logic [7:0]         i_right_limit,
    output t_pix_stat          o_stat,
    output logic [AW-1:0]      o_addr
);

    logic [COORD_W:0] sx;
    logic             hit;
    logic [31:0]      addr_full;
    t_pix_stat        r_stat;
    logic [AW-1:0]    r_addr;

    // Shift x by the left offset and clip against width, limit and height
    assign sx  = {1'b0, i_x} + {{(COORD_W - 6){1'b0}}, i_left_offset};
    assign hit = (32'(sx) < 32'(WIDTH)) && (32'(sx) < 32'(i_right_limit))
              && (32'(i_y) < 32'(HEIGHT));

    // Page row times width plus column; only meaningful on a hit
    assign addr_full = 32'(i_y[COORD_W-1:3]) * 32'(WIDTH) + 32'(sx);

    // Hold the result for the read-modify-write
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stat.hit  <= hit;
            r_stat.mask <= 8'(1) << i_y[2:0];
            r_addr      <= AW'(addr_full);
        end
    end

    assign o_stat = r_stat;
    assign o_addr = r_addr;

endmodule

// File: rtl/core/page_framebuffer_draw_engine_top.sv
// Top level of the page framebuffer draw engine: APB registers, sequencer, store, output.
// Each request runs to completion before the next is accepted: every drawn pixel is a
// read-modify-write through the calc, read and write states; a clipped pixel skips the
// write. Reset (synchronous, active low) clears control state, then sweeps the store to
// zero, one byte a cycle, over all STORE_BYTES bytes before the first request.
module page_framebuffer_draw_engine_top
    import pfde_pkg::*;
#(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [9:0]  i_x_a,
    input  logic [9:0]  i_y_a,
    input  logic [9:0]  i_x_b,
    input  logic [9:0]  i_y_b,
    input  logic [9:0]  i_read_index,
    // Result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PAGES       = (HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = WIDTH * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);

    // Sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SEG  = 4'd2;
    localparam logic [3:0] S_CALC = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_WR   = 4'd5;
    localparam logic [3:0] S_RDB  = 4'd6;
    localparam logic [3:0] S_RDD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]         r_state, n_state;
    logic [2:0]         r_cmd, n_cmd;
    logic [9:0]         r_xa, n_xa, r_ya, n_ya, r_xb, n_xb, r_yb, n_yb, r_ri, n_ri;
    logic               r_on, n_on;
    logic [1:0]         r_seg, n_seg;
    logic               r_last, n_last;
    logic               r_horiz, n_horiz;
    logic [COORD_W-1:0] r_cur, n_cur, r_end, n_end, r_fix, n_fix;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_clr_cmd, n_clr_cmd;
    logic [7:0]         r_res, n_res;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_data, n_out_data;
    logic [6:0]         r_left_offset;
    logic [7:0]         r_right_limit;

    logic               accept;
    logic               cfg_wr;
    logic               adv;
    logic [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi, x_w, x_w1, y_h1;
    logic [COORD_W-1:0] pu_x, pu_y;
    t_pix_stat          pu_stat;
    logic [AW-1:0]      pu_addr;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
    logic [7:0]         mem_wr_data, mem_rd_data;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_read_data = r_out_data;

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {24'd0, r_right_limit} : {25'd0, r_left_offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_offset <= LEFT_OFFSET_RST;
            r_right_limit <= RIGHT_LIMIT_RST;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_right_limit <= pwdata[7:0];
            end else begin
                r_left_offset <= pwdata[6:0];
            end
        end
    end

    // Span endpoints: ordered ends and rectangle edges
    assign x_lo = (r_xa <= r_xb) ? {1'b0, r_xa} : {1'b0, r_xb};
    assign x_hi = (r_xa <= r_xb) ? {1'b0, r_xb} : {1'b0, r_xa};
    assign y_lo = (r_ya <= r_yb) ? {1'b0, r_ya} : {1'b0, r_yb};
    assign y_hi = (r_ya <= r_yb) ? {1'b0, r_yb} : {1'b0, r_ya};
    assign x_w  = {1'b0, r_xa} + {1'b0, r_xb};
    assign x_w1 = x_w - COORD_W'(1);
    assign y_h1 = {1'b0, r_ya} + {1'b0, r_yb} - COORD_W'(1);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_xa        = r_xa;
        n_ya        = r_ya;
        n_xb        = r_xb;
        n_yb        = r_yb;
        n_ri        = r_ri;
        n_on        = r_on;
        n_seg       = r_seg;
        n_last      = r_last;
        n_horiz     = r_horiz;
        n_cur       = r_cur;
        n_end       = r_end;
        n_fix       = r_fix;
        n_clr_addr  = r_clr_addr;
        n_clr_cmd   = r_clr_cmd;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        adv         = 1'b0;

        // Drop the result once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(STORE_BYTES - 1)) begin
                    n_state = r_clr_cmd ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd;
                    n_xa  = i_x_a;
                    n_ya  = i_y_a;
                    n_xb  = i_x_b;
                    n_yb  = i_y_b;
                    n_ri  = i_read_index;
                    n_on  = (i_cmd != CMD_CLR_PIXEL) && (i_cmd != CMD_CLR_HSPAN);
                    n_seg = 2'd0;
                    n_res = 8'd0;
                    unique case (i_cmd) inside
                        CMD_CLEAR_ALL: begin
                            n_clr_addr = '0;
                            n_clr_cmd  = 1'b1;
                            n_state    = S_CLR;
                        end
                        CMD_READ: begin
                            n_state = (32'(i_read_index) < 32'(STORE_BYTES)) ? S_RDB : S_DONE;
                        end
                        default: begin
                            n_state = S_SEG;
                        end
                    endcase
                end
            end
            S_SEG: begin
                n_state = S_CALC;
                n_last  = 1'b1;
                case (r_cmd) inside
                    CMD_SET_PIXEL, CMD_CLR_PIXEL: begin
                        n_horiz = 1'b1;
                        n_fix   = {1'b0, r_ya};
                        n_cur   = {1'b0, r_xa};
                        n_end   = {1'b0, r_xa};
                    end
                    CMD_SET_HSPAN, CMD_CLR_HSPAN: begin
                        n_horiz = 1'b1;
                        n_fix   = {1'b0, r_ya};
                        n_cur   = x_lo;
                        n_end   = x_hi;
                    end
                    CMD_SET_VSPAN: begin
                        n_horiz = 1'b0;
                        n_fix   = {1'b0, r_xa};
                        n_cur   = y_lo;
                        n_end   = y_hi;
                    end
                    default: begin
                        // Rectangle: top, bottom, left, right edges in turn
                        n_last = (r_seg == 2'd3);
                        n_horiz = !r_seg[1];
                        case (r_seg)
                            2'd0: begin
                                n_fix = {1'b0, r_ya};
                                n_cur = {1'b0, r_xa};
                                n_end = x_w1;
                            end
                            2'd1: begin
                                n_fix = y_h1;
                                n_cur = {1'b0, r_xa};
                                n_end = x_w;
                            end
                            2'd2: begin
                                n_fix = {1'b0, r_xa};
                                n_cur = {1'b0, r_ya};
                                n_end = y_h1;
                            end
                            default: begin
                                n_fix = x_w;
                                n_cur = {1'b0, r_ya};
                                n_end = y_h1;
                            end
                        endcase
                        // Zero width or height draws nothing
                        if (r_xb == 10'd0 || r_yb == 10'd0) begin
                            n_state = S_DONE;
                        end
                    end
                endcase
            end
            S_CALC: begin
                n_state = S_RD;
            end
            S_RD: begin
                if (pu_stat.hit) begin
                    n_state = S_WR;
                end else begin
                    adv = 1'b1;
                end
            end
            S_WR: begin
                adv = 1'b1;
            end
            S_RDB: begin
                n_state = S_RDD;
            end
            S_RDD: begin
                n_res   = mem_rd_data;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_clr_cmd   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance to the next pixel, the next edge, or finish
        if (adv) begin
            if (r_cur == r_end) begin
                if (r_last) begin
                    n_state = S_DONE;
                end else begin
                    n_seg   = r_seg + 2'd1;
                    n_state = S_SEG;
                end
            end else begin
                n_cur   = r_cur + COORD_W'(1);
                n_state = S_CALC;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_cmd   <= n_clr_cmd;
            r_out_valid <= n_out_valid;
        end
    end

    // Request payload and loop registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_xa       <= n_xa;
        r_ya       <= n_ya;
        r_xb       <= n_xb;
        r_yb       <= n_yb;
        r_ri       <= n_ri;
        r_on       <= n_on;
        r_seg      <= n_seg;
        r_last     <= n_last;
        r_horiz    <= n_horiz;
        r_cur      <= n_cur;
        r_end      <= n_end;
        r_fix      <= n_fix;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    // Shared pixel unit
    assign pu_x = r_horiz ? r_cur : r_fix;
    assign pu_y = r_horiz ? r_fix : r_cur;

    pfde_pixel_unit #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT),
        .AW     (AW)
    ) u_pixel_unit (
        .i_clk         (i_clk),
        .i_load        (r_state == S_CALC),
        .i_x           (pu_x),
        .i_y           (pu_y),
        .i_left_offset (r_left_offset),
        .i_right_limit (r_right_limit),
        .o_stat        (pu_stat),
        .o_addr        (pu_addr)
    );

    // Store access: clear sweep, pixel read-modify-write, byte read
    assign mem_re      = ((r_state == S_RD) && pu_stat.hit) || (r_state == S_RDB);
    assign mem_rd_addr = (r_state == S_RDB) ? AW'(r_ri) : pu_addr;
    assign mem_we      = (r_state == S_CLR) || (r_state == S_WR);
    assign mem_wr_addr = (r_state == S_CLR) ? r_clr_addr : pu_addr;
    assign mem_wr_data = (r_state == S_CLR) ? 8'd0
                       : (r_on ? (mem_rd_data | pu_stat.mask)
                               : (mem_rd_data & ~pu_stat.mask));

    pfde_frame_mem #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_frame_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_re      (mem_re),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

`ifndef SYNTHESIS
    // A pixel write always follows a read of a pixel that passed the clip
    a_wr_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_RD && $past(pu_stat.hit)))
        else $error("pixel write without a preceding clipped-in read");

    // The clear sweep never reads the store
    a_clr_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !mem_re)
        else $error("store read during clear sweep");

    // A result appears only out of the done state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside done state");

    // The loop position never runs past its end
    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_cur <= r_end))
        else $error("span position beyond its end");
`endif

endmodule

// File: tb/tb.sv
// Testbench for the page framebuffer draw engine: store predictor, request driver, result checks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pfde_pkg::*;

    localparam int WIDTH           = 128;
    localparam int HEIGHT          = 64;
    localparam int STORE_BYTES     = WIDTH * ((HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS);
    localparam int WATCHDOG_CYCLES = 60000;

    // Register byte addresses
    localparam logic [2:0] REG_LEFT_OFFSET = 3'd0;
    localparam logic [2:0] REG_RIGHT_LIMIT = 3'd4;

    typedef enum int {STALL_NONE, STALL_SCATTER, STALL_BURSTS} t_stall_mode;

    typedef struct {
        logic [2:0] cmd;
        logic [9:0] x_a;
        logic [9:0] y_a;
        logic [9:0] x_b;
        logic [9:0] y_b;
        logic [9:0] read_index;
    } t_draw_req;

    // Own copy of the page store and registers; one expected byte per request
    class page_store_predictor;
        logic [7:0]  frame [STORE_BYTES];
        logic [6:0]  left_offset;
        logic [7:0]  right_limit;
        logic [7:0]  expected_bytes [$];
        int unsigned mismatches;

        function new();
            foreach (frame[i]) frame[i] = '0;
            left_offset = LEFT_OFFSET_RST;
            right_limit = RIGHT_LIMIT_RST;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] data);
            case (addr)
                REG_LEFT_OFFSET: left_offset = data[6:0];
                REG_RIGHT_LIMIT: right_limit = data[7:0];
                default: ;
            endcase
        endfunction

        // Set or clear one pixel; drop it when clipped
        function void plot(int x, int y, bit on);
            int sx;
            int pos;
            sx = x + int'(left_offset);
            if (sx >= WIDTH || sx >= int'(right_limit) || y >= HEIGHT) return;
            pos = (y / PAGE_ROWS) * WIDTH + sx;
            frame[pos][y % PAGE_ROWS] = on;
        endfunction

        function void fill_row(int a, int b, int y, bit on);
            int t;
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            for (int x = a; x <= b; x++) plot(x, y, on);
        endfunction

        function void fill_column(int x, int a, int b);
            int t;
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            for (int y = a; y <= b; y++) plot(x, y, 1'b1);
        endfunction

        // Apply one accepted request and queue the byte it returns
        function void note_request(t_draw_req r);
            int         xa;
            int         ya;
            int         xb;
            int         yb;
            logic [7:0] data;
            xa   = int'(r.x_a);
            ya   = int'(r.y_a);
            xb   = int'(r.x_b);
            yb   = int'(r.y_b);
            data = '0;
            case (r.cmd)
                CMD_SET_PIXEL: plot(xa, ya, 1'b1);
                CMD_CLR_PIXEL: plot(xa, ya, 1'b0);
                CMD_SET_HSPAN: fill_row(xa, xb, ya, 1'b1);
                CMD_CLR_HSPAN: fill_row(xa, xb, ya, 1'b0);
                CMD_SET_VSPAN: fill_column(xa, ya, yb);
                CMD_RECT: begin
                    // Top edge stops one short of the right edge column
                    if (xb != 0 && yb != 0) begin
                        fill_row(xa, xa + xb - 1, ya, 1'b1);
                        fill_row(xa, xa + xb, ya + yb - 1, 1'b1);
                        fill_column(xa, ya, ya + yb - 1);
                        fill_column(xa + xb, ya, ya + yb - 1);
                    end
                end
                CMD_CLEAR_ALL: foreach (frame[i]) frame[i] = '0;
                default: begin
                    if (int'(r.read_index) < STORE_BYTES) data = frame[r.read_index];
                end
            endcase
            expected_bytes.push_back(data);
        endfunction

        function void check_read_data(logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                $error("read_data: no request pending, expected none actual %0h", got);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want) begin
                $error("read_data mismatch: expected %0h actual %0h", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [2:0]  i_cmd        = CMD_READ;
    logic [9:0]  i_x_a        = '0;
    logic [9:0]  i_y_a        = '0;
    logic [9:0]  i_x_b        = '0;
    logic [9:0]  i_y_b        = '0;
    logic [9:0]  i_read_index = '0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [7:0]  o_read_data;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    page_store_predictor sb = new();

    int          burst_left  = 0;
    int          last_pos    = 0;
    int          quiet_cycles = 0;
    int          stall_run   = 0;
    t_stall_mode stall_mode  = STALL_NONE;

    page_framebuffer_draw_engine_top #(
        .WIDTH (WIDTH),
        .HEIGHT(HEIGHT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_x_a       (i_x_a),
        .i_y_a       (i_y_a),
        .i_x_b       (i_x_b),
        .i_y_b       (i_y_b),
        .i_read_index(i_read_index),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_read_data (o_read_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the result channel in runs: none, scattered, or long bursts
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_run  = $urandom_range(8, 64);
        end
        stall_run--;
        case (stall_mode)
            STALL_NONE:    i_stall <= 1'b0;
            STALL_SCATTER: i_stall <= ($urandom_range(0, 2) == 0);
            default:       i_stall <= ((stall_run % 16) < 9);
        endcase
    end

    // Check every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) sb.check_read_data(o_read_data);
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int any10();
        return $urandom_range(0, 1023);
    endfunction

    function automatic int near_x();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 140);
    endfunction

    function automatic int near_y();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 70);
    endfunction

    // Pick the other span end, either order, kept inside 10 bits
    function automatic int far_end(int a, int len);
        if ($urandom_range(0, 1) == 1 && a >= len) return a - len;
        if (a + len <= 1023) return a + len;
        return (a >= len) ? a - len : 1023;
    endfunction

    // Drive one request in bursts with random gaps; note it once accepted
    task automatic send(logic [2:0] cmd, int xa, int ya, int xb, int yb, int ri);
        int        gap;
        t_draw_req r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 5);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_cmd        = cmd;
        i_x_a        = 10'(xa);
        i_y_a        = 10'(ya);
        i_x_b        = 10'(xb);
        i_y_b        = 10'(yb);
        i_read_index = 10'(ri);
        do @(posedge i_clk); while (o_stall !== 1'b0);
        r.cmd        = cmd;
        r.x_a        = 10'(xa);
        r.y_a        = 10'(ya);
        r.x_b        = 10'(xb);
        r.y_b        = 10'(yb);
        r.read_index = 10'(ri);
        sb.note_request(r);
    endtask

    // Hold off until every expected byte has come back
    task automatic drain();
        @(negedge i_clk);
        i_valid    = 1'b0;
        burst_left = 0;
        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(addr, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_directed();
        // Corners and single-step clipping
        send(CMD_SET_PIXEL, 0, 0, any10(), any10(), any10());
        send(CMD_SET_PIXEL, 127, 63, any10(), any10(), any10());
        send(CMD_SET_PIXEL, 1023, 1023, any10(), any10(), any10());
        send(CMD_SET_PIXEL, 5, 64, any10(), any10(), any10());
        send(CMD_SET_PIXEL, 128, 0, any10(), any10(), any10());
        send(CMD_READ, any10(), any10(), any10(), any10(), 0);
        send(CMD_READ, any10(), any10(), any10(), any10(), 1023);
        send(CMD_CLR_PIXEL, 127, 63, any10(), any10(), any10());
        send(CMD_READ, any10(), any10(), any10(), any10(), 1023);
        // Spans, some given in reverse order
        send(CMD_SET_HSPAN, 30, 9, 10, any10(), any10());
        send(CMD_CLR_HSPAN, 15, 9, 20, any10(), any10());
        send(CMD_READ, any10(), any10(), any10(), any10(), 140);
        send(CMD_SET_VSPAN, 40, 1023, any10(), 3, any10());
        send(CMD_READ, any10(), any10(), any10(), any10(), 40);
        send(CMD_READ, any10(), any10(), any10(), any10(), 296);
        // Zero-size rectangles draw nothing; others keep the uneven edges
        send(CMD_RECT, 50, 30, 0, 5, any10());
        send(CMD_RECT, 50, 30, 5, 0, any10());
        send(CMD_RECT, 60, 10, 8, 6, any10());
        send(CMD_READ, any10(), any10(), any10(), any10(), 188);
        send(CMD_READ, any10(), any10(), any10(), any10(), 196);
        send(CMD_RECT, 120, 60, 20, 10, any10());
        send(CMD_SET_HSPAN, 0, 0, 1023, any10(), any10());
        send(CMD_READ, any10(), any10(), any10(), any10(), 127);
        send(CMD_CLEAR_ALL, any10(), any10(), any10(), any10(), any10());
        send(CMD_READ, any10(), any10(), any10(), any10(), 1023);
    endtask

    task automatic send_random();
        int         pick;
        int         len;
        logic [2:0] cmd;
        int         xa;
        int         ya;
        int         xb;
        int         yb;
        int         ri;
        pick = $urandom_range(0, 99);
        xa   = near_x();
        ya   = near_y();
        xb   = any10();
        yb   = any10();
        ri   = ($urandom_range(0, 1) == 1) ? any10() : last_pos;
        len  = ($urandom_range(0, 99) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
        if (pick < 30) begin
            cmd = CMD_READ;
        end else if (pick < 42) begin
            cmd = CMD_SET_PIXEL;
        end else if (pick < 50) begin
            cmd = CMD_CLR_PIXEL;
        end else if (pick < 68) begin
            cmd = (pick < 60) ? CMD_SET_HSPAN : CMD_CLR_HSPAN;
            xb  = far_end(xa, len);
        end else if (pick < 78) begin
            cmd = CMD_SET_VSPAN;
            yb  = far_end(ya, len % 25);
        end else if (pick < 86) begin
            cmd = CMD_RECT;
            if ($urandom_range(0, 49) == 0) begin
                xb = any10();
                yb = any10();
            end else begin
                xb = $urandom_range(0, 40);
                yb = $urandom_range(0, 24);
            end
        end else if (pick < 87) begin
            cmd = CMD_CLEAR_ALL;
        end else begin
            // Stray fields over their full range on cheap commands
            case ($urandom_range(0, 2))
                0:       cmd = CMD_SET_PIXEL;
                1:       cmd = CMD_CLR_PIXEL;
                default: cmd = CMD_READ;
            endcase
            xa = any10();
            ya = any10();
            ri = any10();
        end
        send(cmd, xa, ya, xb, yb, ri);
        if (cmd != CMD_READ && cmd != CMD_CLEAR_ALL)
            last_pos = ((ya / PAGE_ROWS) * WIDTH + xa + int'(sb.left_offset)) % STORE_BYTES;
    endtask

    // Reprogram the clip window while idle, then run random requests
    task automatic run_phase(int left, int right, int count);
        drain();
        apb_write(REG_LEFT_OFFSET, left);
        apb_write(REG_RIGHT_LIMIT, right);
        repeat (count) send_random();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        run_phase(0, 128, 200);
        run_phase(127, 128, 150);
        run_phase(0, 0, 100);
        run_phase(9, 100, 250);
        run_phase(64, 128, 200);
        run_phase($urandom_range(0, 127), $urandom_range(0, 128), 300);
        drain();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: page_framebuffer_draw_engine_top.f
rtl/core/pfde_pkg.sv
rtl/core/pfde_frame_mem.sv
rtl/core/pfde_pixel_unit.sv
rtl/core/page_framebuffer_draw_engine_top.sv
tb/tb.sv
